FILE: rtl/core/tts_pkg.sv
// shared types and constants for the timed trigger scheduler
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package tts_pkg;

	// default number of pending trigger slots
	localparam int CAPACITY_DEF = 64;

	// field widths
	localparam int TS_W    = 64;
	localparam int LEN_W   = 14;
	localparam int TRACK_W = 8;
	localparam int CHOP_W  = 8;
	localparam int VEL_W   = 7;

	// input beat kinds
	localparam logic KIND_SCHEDULE = 1'b0;
	localparam logic KIND_ADVANCE  = 1'b1;

	// one stored trigger
	typedef struct packed {
		logic [TS_W-1:0]           ts;
		logic [TRACK_W-1:0]        track;
		logic signed [CHOP_W-1:0]  chop;
		logic                      on_flag;
		logic [VEL_W-1:0]          vel;
	} entry_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic sched_write;  // append the input trigger
		logic scan_start;   // latch block bounds, clear scan counters
		logic scan_read;    // read the next pending slot
		logic finish;       // commit kept count and move the clock
		logic emit;         // pop the earliest due trigger into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;         // store holds CAPACITY triggers
		logic rd_done;      // every pending slot has been read
		logic eval_busy;    // a read is still in flight
		logic due_empty;    // sorted due row is empty
		logic out_free;     // output register can take a beat
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tts_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/tts_ctrl.sv
// controller state machine: sequences schedule, scan and emit phases
// depends on tts_pkg
`default_nettype none

module tts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              kind,
	output logic                   in_stall,
	output tts_pkg::cmd_t          cmd,
	input  wire tts_pkg::status_t  st
);

	import tts_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (kind == KIND_SCHEDULE) begin
						cmd.sched_write = !st.full;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_read = !st.rd_done;
				if (st.rd_done && !st.eval_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = !st.due_empty && st.out_free;
				if (st.due_empty) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// emit phase ends once the due row is drained
	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && st.due_empty) |=> (state_q == ST_IDLE))
		else $error("emit phase did not end on empty due row");

	// no scan commands outside the scan phase
	a_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_read || cmd.finish) |-> (state_q == ST_SCAN))
		else $error("scan command outside scan phase");

	// input beats are taken only in idle
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input open outside idle");

endmodule

`default_nettype wire

FILE: rtl/core/tts_datapath.sv
// datapath: pending store, scan and compaction, sorted due row, output register
// depends on tts_pkg and tts_ram
`default_nettype none

module tts_datapath #(
	parameter int CAPACITY = tts_pkg::CAPACITY_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tts_pkg::cmd_t                     cmd,
	output tts_pkg::status_t                       st,
	input  wire tts_pkg::entry_t                   in_entry,
	input  wire logic [tts_pkg::LEN_W-1:0]         block_length,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [tts_pkg::LEN_W-1:0]              block_offset,
	output logic [tts_pkg::TRACK_W-1:0]            out_track,
	output logic signed [tts_pkg::CHOP_W-1:0]      out_chop,
	output logic                                   out_on,
	output logic [tts_pkg::VEL_W-1:0]              out_velocity,
	output logic                                   last_due
);

	import tts_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int EW = $bits(entry_t);

	// control counters and clock
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    rd_idx_q;
	logic [CW-1:0]    keep_q;
	logic [CW-1:0]    due_n_q;
	logic             eval_s1;
	logic [TS_W-1:0]  clock_q;

	// block bounds of the current advance
	logic [TS_W-1:0]  start_q;
	logic [TS_W-1:0]  end_q;
	logic [LEN_W-1:0] len_q;

	// memory ports
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	entry_t           ram_wdata;
	logic [EW-1:0]    ram_rdata;
	entry_t           rd_entry;

	// scan classification
	logic             is_due;
	logic             ins;
	logic             pop;

	// sorted due row
	entry_t           cell_q [CAPACITY];
	logic [CAPACITY-1:0] gt;

	// output register
	logic             out_valid_q;
	logic [LEN_W-1:0] offset_q;
	logic [TRACK_W-1:0] track_q;
	logic signed [CHOP_W-1:0] chop_q;
	logic             on_q;
	logic [VEL_W-1:0] vel_q;
	logic             last_q;

	// offset of the head trigger
	logic             late;
	logic [TS_W-1:0]  diff;
	logic [LEN_W-1:0] head_offset;

	assign rd_entry = entry_t'(ram_rdata);
	assign is_due   = rd_entry.ts < end_q;
	assign ins      = eval_s1 && is_due;
	assign pop      = cmd.emit;

	// status to controller
	assign st.full      = (count_q == CW'(CAPACITY));
	assign st.rd_done   = (rd_idx_q == count_q);
	assign st.eval_busy = eval_s1;
	assign st.due_empty = (due_n_q == '0);
	assign st.out_free  = !out_valid_q || !out_stall;

	// memory write: appended trigger or a kept trigger moved down
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = in_entry;
		if (cmd.sched_write) begin
			ram_we = 1'b1;
		end else if (eval_s1 && !is_due) begin
			ram_we    = 1'b1;
			ram_waddr = keep_q[AW-1:0];
			ram_wdata = rd_entry;
		end
	end

	tts_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// counters, clock and scan pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
			keep_q   <= '0;
			due_n_q  <= '0;
			eval_s1  <= 1'b0;
			clock_q  <= '0;
		end else begin
			eval_s1 <= cmd.scan_read;
			if (cmd.sched_write) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.scan_start) begin
				rd_idx_q <= '0;
				keep_q   <= '0;
			end
			if (cmd.scan_read) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (eval_s1 && !is_due) begin
				keep_q <= keep_q + CW'(1);
			end
			if (ins) begin
				due_n_q <= due_n_q + CW'(1);
			end else if (pop) begin
				due_n_q <= due_n_q - CW'(1);
			end
			if (cmd.finish) begin
				count_q <= keep_q;
				clock_q <= end_q;
			end
		end
	end

	// block bounds
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			start_q <= clock_q;
			end_q   <= clock_q + TS_W'(block_length);
			len_q   <= block_length;
		end
	end

	// due row cells: stable insertion by time, shift toward the head on pop
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic   prev_gt;
		entry_t prev_cell;
		entry_t next_cell;

		assign gt[g] = (CW'(g) < due_n_q) && (cell_q[g].ts > rd_entry.ts);

		if (g == 0) begin : g_head
			assign prev_gt   = 1'b0;
			assign prev_cell = rd_entry;
		end else begin : g_body
			assign prev_gt   = gt[g-1];
			assign prev_cell = cell_q[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign next_cell = cell_q[g];
		end else begin : g_inner
			assign next_cell = cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (ins) begin
				if (prev_gt) begin
					cell_q[g] <= prev_cell;
				end else if (gt[g] || (CW'(g) == due_n_q)) begin
					cell_q[g] <= rd_entry;
				end
			end else if (pop) begin
				cell_q[g] <= next_cell;
			end
		end
	end

	// head offset, clamped to 0..block length
	assign late = cell_q[0].ts < start_q;
	assign diff = cell_q[0].ts - start_q;
	always_comb begin
		if (late) begin
			head_offset = '0;
		end else if (diff > TS_W'(len_q)) begin
			head_offset = len_q;
		end else begin
			head_offset = diff[LEN_W-1:0];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			offset_q <= head_offset;
			track_q  <= cell_q[0].track;
			chop_q   <= cell_q[0].chop;
			on_q     <= cell_q[0].on_flag;
			vel_q    <= cell_q[0].vel;
			last_q   <= (due_n_q == CW'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign block_offset = offset_q;
	assign out_track    = track_q;
	assign out_chop     = chop_q;
	assign out_on       = on_q;
	assign out_velocity = vel_q;
	assign last_due     = last_q;

	// store never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CW'(CAPACITY)) && (due_n_q <= CW'(CAPACITY)))
		else $error("pending or due count above capacity");

	// every slot read so far is either kept, due or still in flight
	a_scan_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_read || eval_s1) |->
		((CW+1)'(keep_q) + (CW+1)'(due_n_q) + (CW+1)'(eval_s1) == (CW+1)'(rd_idx_q)))
		else $error("scan lost or duplicated a trigger");

	// insertion and pop never coincide
	a_no_ins_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ins && pop))
		else $error("insert and pop in the same cycle");

	// due row head is in time order
	if (CAPACITY > 1) begin : g_order_chk
		a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
			(due_n_q >= CW'(2)) |-> (cell_q[0].ts <= cell_q[1].ts))
			else $error("due row out of order");
	end

endmodule

`default_nettype wire

FILE: rtl/core/timed_trigger_scheduler_core.sv
// top level of the timed trigger scheduler
// depends on tts_pkg, tts_ctrl, tts_datapath (and tts_ram through it)
//
// Holds up to CAPACITY pending triggers in a single-port-write, single-port-read
// memory. A schedule beat appends one trigger (dropped when the store is full).
// An advance beat reads every pending trigger once, one slot per cycle through
// the memory read port: due triggers go into a sorted row of cells by stable
// insertion, the rest are compacted back into the memory in order. Then the due
// triggers leave in time order, one beat per cycle while out_stall is low, and
// the controller returns to idle once the due row is empty. The input is stalled
// for the whole advance. A beat whose results are waiting in the output register
// does not block the return to idle.
`default_nettype none

module timed_trigger_scheduler_core #(
	parameter int CAPACITY = tts_pkg::CAPACITY_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              kind,
	input  wire logic [tts_pkg::TS_W-1:0]          event_time,
	input  wire logic [tts_pkg::LEN_W-1:0]         block_length,
	input  wire logic [tts_pkg::TRACK_W-1:0]       track_index,
	input  wire logic signed [tts_pkg::CHOP_W-1:0] chop_index,
	input  wire logic                              note_on,
	input  wire logic [tts_pkg::VEL_W-1:0]         hit_velocity,

	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [tts_pkg::LEN_W-1:0]              block_offset,
	output logic [tts_pkg::TRACK_W-1:0]            out_track,
	output logic signed [tts_pkg::CHOP_W-1:0]      out_chop,
	output logic                                   out_on,
	output logic [tts_pkg::VEL_W-1:0]              out_velocity,
	output logic                                   last_due
);

	import tts_pkg::*;

	cmd_t    cmd;
	status_t st;
	entry_t  in_entry;

	// incoming trigger as a store entry
	assign in_entry.ts      = event_time;
	assign in_entry.track   = track_index;
	assign in_entry.chop    = chop_index;
	assign in_entry.on_flag = note_on;
	assign in_entry.vel     = hit_velocity;

	tts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st)
	);

	tts_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.in_entry     (in_entry),
		.block_length (block_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.block_offset (block_offset),
		.out_track    (out_track),
		.out_chop     (out_chop),
		.out_on       (out_on),
		.out_velocity (out_velocity),
		.last_due     (last_due)
	);

endmodule

`default_nettype wire

FILE: tb/tb_timed_trigger_scheduler_core.sv
`timescale 1ns / 1ps
// testbench for timed_trigger_scheduler_core: schedule and advance beats with random idling
// on both channels, each due trigger checked against an in-bench copy of the trigger store
// depends on tts_pkg and the scheduler core rtl

module tb_timed_trigger_scheduler_core;
	import tts_pkg::*;

	localparam int CAP         = CAPACITY_DEF;
	localparam int ITEMS       = 450;
	localparam int STALL_LIMIT = 2000;

	// one due trigger as it leaves the block
	typedef struct packed {
		logic [LEN_W-1:0]         offset;
		logic [TRACK_W-1:0]       track;
		logic signed [CHOP_W-1:0] chop;
		logic                     on_flag;
		logic [VEL_W-1:0]         vel;
		logic                     last;
	} fire_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     in_valid     = 1'b0;
	logic                     in_stall;
	logic                     kind         = KIND_SCHEDULE;
	logic [TS_W-1:0]          event_time   = '0;
	logic [LEN_W-1:0]         block_length = '0;
	logic [TRACK_W-1:0]       track_index  = '0;
	logic signed [CHOP_W-1:0] chop_index   = '0;
	logic                     note_on      = 1'b0;
	logic [VEL_W-1:0]         hit_velocity = '0;
	logic                     out_valid;
	logic                     out_stall    = 1'b0;
	logic [LEN_W-1:0]         block_offset;
	logic [TRACK_W-1:0]       out_track;
	logic signed [CHOP_W-1:0] out_chop;
	logic                     out_on;
	logic [VEL_W-1:0]         out_velocity;
	logic                     last_due;

	// mirror of the trigger store and the sample clock
	entry_t          model_pending[$];
	logic [TS_W-1:0] model_clock = '0;
	fire_t           expected_fires[$];
	fire_t           want;
	logic [TS_W-1:0] last_time   = '0;
	int              in_gap_max  = 10;
	int              out_gap_max = 10;
	int              beats_sent  = 0;
	int              mismatches  = 0;
	int              idle_cycles = 0;

	timed_trigger_scheduler_core #(
		.CAPACITY(CAP)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.event_time   (event_time),
		.block_length (block_length),
		.track_index  (track_index),
		.chop_index   (chop_index),
		.note_on      (note_on),
		.hit_velocity (hit_velocity),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.block_offset (block_offset),
		.out_track    (out_track),
		.out_chop     (out_chop),
		.out_on       (out_on),
		.out_velocity (out_velocity),
		.last_due     (last_due)
	);

	always #5 clk = ~clk;

	// append a trigger unless the store is full
	function automatic void predict_schedule(input entry_t e);
		if (model_pending.size() < CAP)
			model_pending.insert(model_pending.size(), e);
	endfunction

	// pull due triggers in stable time order, keep the rest, move the clock
	function automatic void predict_advance(input logic [LEN_W-1:0] len);
		entry_t          due[$];
		entry_t          kept[$];
		logic [TS_W-1:0] span;
		logic [TS_W-1:0] stop;
		logic [TS_W-1:0] delta;
		fire_t           f;
		int              j;
		span = TS_W'(len);
		stop = model_clock + span;
		foreach (model_pending[i]) begin
			if (model_pending[i].ts < stop) begin
				j = due.size();
				while (j > 0 && due[j-1].ts > model_pending[i].ts)
					j--;
				due.insert(j, model_pending[i]);
			end else begin
				kept.insert(kept.size(), model_pending[i]);
			end
		end
		model_pending = kept;
		foreach (due[i]) begin
			// late triggers fire at the block start
			if (due[i].ts < model_clock)
				delta = '0;
			else
				delta = due[i].ts - model_clock;
			if (delta > span)
				delta = span;
			f.offset  = delta[LEN_W-1:0];
			f.track   = due[i].track;
			f.chop    = due[i].chop;
			f.on_flag = due[i].on_flag;
			f.vel     = due[i].vel;
			f.last    = (i == due.size() - 1);
			expected_fires.insert(expected_fires.size(), f);
		end
		model_clock = stop;
	endfunction

	// drive one beat after a random gap, hold it until accepted
	task automatic send_beat(input logic k, input logic [TS_W-1:0] t,
		input logic [LEN_W-1:0] len, input logic [TRACK_W-1:0] trk,
		input logic signed [CHOP_W-1:0] chp, input logic onf, input logic [VEL_W-1:0] vel);
		int     gap;
		entry_t e;
		gap = $urandom_range(in_gap_max, 0);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		kind         <= k;
		event_time   <= t;
		block_length <= len;
		track_index  <= trk;
		chop_index   <= chp;
		note_on      <= onf;
		hit_velocity <= vel;
		do @(posedge clk); while (!(in_valid && !in_stall));
		if (k == KIND_SCHEDULE) begin
			e.ts      = t;
			e.track   = trk;
			e.chop    = chp;
			e.on_flag = onf;
			e.vel     = vel;
			predict_schedule(e);
		end else begin
			predict_advance(len);
		end
		beats_sent++;
	endtask

	task automatic send_trigger(input logic [TS_W-1:0] t, input logic [TRACK_W-1:0] trk,
		input logic signed [CHOP_W-1:0] chp, input logic onf, input logic [VEL_W-1:0] vel);
		send_beat(KIND_SCHEDULE, t, LEN_W'($urandom_range(16383, 0)), trk, chp, onf, vel);
	endtask

	task automatic send_random_trigger(input logic [TS_W-1:0] t);
		send_trigger(t, TRACK_W'($urandom_range(255, 0)), CHOP_W'($urandom_range(255, 0)),
			1'($urandom_range(1, 0)), VEL_W'($urandom_range(127, 0)));
	endtask

	// unused trigger fields carry noise on an advance
	task automatic send_advance(input logic [LEN_W-1:0] len);
		send_beat(KIND_ADVANCE, {$urandom, $urandom}, len, TRACK_W'($urandom_range(255, 0)),
			CHOP_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
			VEL_W'($urandom_range(127, 0)));
	endtask

	// take the held beat off the bus, then wait for every expected fire
	task automatic wait_for_fires();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_fires.size() != 0)
			@(posedge clk);
	endtask

	// mostly near the clock, some late, some repeats of the previous time, some far ahead
	function automatic logic [TS_W-1:0] pick_time();
		int unsigned     r;
		int unsigned     back;
		logic [TS_W-1:0] t;
		r = $urandom_range(9, 0);
		if (r == 0) begin
			back = $urandom_range(5000, 1);
			t = (model_clock > back) ? model_clock - back : '0;
		end else if (r == 1) begin
			t = last_time;
		end else if (r < 8) begin
			t = model_clock + $urandom_range(2047, 0);
		end else begin
			t = model_clock + $urandom_range(40000, 2048);
		end
		last_time = t;
		return t;
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(9, 0);
		if (r == 0)
			return '0;
		else if (r == 1)
			return LEN_W'($urandom_range(16383, 8192));
		else
			return LEN_W'($urandom_range(2047, 1));
	endfunction

	// field extremes, late triggers, equal times, block edges, empty and long blocks
	task automatic test_directed();
		logic [TS_W-1:0] t0;
		send_advance(0);
		send_advance(100);
		t0 = model_clock;
		send_trigger(t0 + 5, 8'd0, -8'sd128, 1'b0, 7'd0);
		send_trigger(t0 + 5, 8'd255, 8'sd127, 1'b1, 7'd127);
		send_trigger('0, 8'h5a, -8'sd1, 1'b1, 7'd64);
		send_trigger(t0 + 63, 8'd1, 8'sd0, 1'b0, 7'd1);
		send_trigger(t0 + 64, 8'd2, 8'sd1, 1'b1, 7'd2);
		send_trigger(t0 + 2, 8'd3, 8'sd2, 1'b0, 7'd3);
		send_advance(64);
		// zero-length block: only the late trigger fires
		send_trigger(64'd10, 8'd4, -8'sd7, 1'b1, 7'd100);
		send_advance(0);
		// widest block code, above the nominal limit
		send_trigger(model_clock + 16382, 8'd5, 8'sd9, 1'b1, 7'd127);
		send_trigger(model_clock + 16383, 8'd6, 8'sd10, 1'b0, 7'd0);
		send_advance(16383);
		send_advance(8192);
		// far future triggers that stay pending for the rest of the run
		send_trigger('1, 8'd7, 8'sd11, 1'b1, 7'd5);
		send_trigger({1'b1, 63'd0}, 8'd8, -8'sd12, 1'b0, 7'd6);
		send_trigger({$urandom, $urandom}, 8'd9, 8'sd13, 1'b1, 7'd7);
		send_advance(1);
	endtask

	// fill past capacity with no idling, then drain
	task automatic test_store_full();
		int n;
		wait_for_fires();
		in_gap_max  = 0;
		out_gap_max = 0;
		n = CAP - model_pending.size() + 3;
		repeat (n) send_random_trigger(model_clock + $urandom_range(3000, 0));
		send_advance(8192);
		in_gap_max  = 10;
		out_gap_max = 10;
		send_advance(8192);
	endtask

	// bursts of triggers closed by an advance, with loose beats as noise
	task automatic test_random();
		int          burst;
		int unsigned pick;
		while (beats_sent < ITEMS) begin
			if ($urandom_range(7, 0) == 0) begin
				in_gap_max  = ($urandom_range(2, 0) == 0) ? 0 : 10;
				out_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 10;
			end
			pick = $urandom_range(9, 0);
			if (pick < 8) begin
				burst = $urandom_range(8, 1);
				repeat (burst) send_random_trigger(pick_time());
				send_advance(pick_length());
			end else if (pick == 8) begin
				send_advance(pick_length());
			end else begin
				send_random_trigger(pick_time());
			end
		end
	endtask

	// receiver stall, drawn per beat
	initial begin
		int n;
		forever begin
			n = $urandom_range(out_gap_max, 0);
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(arst_n && out_valid && !out_stall));
		end
	end

	// compare each output beat with the oldest expected fire
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_fires.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected beat off=%0d trk=%0d chop=%0d on=%0b vel=%0d last=%0b",
						$time, block_offset, out_track, out_chop, out_on, out_velocity, last_due);
				mismatches++;
			end else begin
				want = expected_fires.pop_front();
				if (block_offset !== want.offset || out_track !== want.track ||
					out_chop !== want.chop || out_on !== want.on_flag ||
					out_velocity !== want.vel || last_due !== want.last) begin
					if (mismatches < 10) begin
						$display("%0t: exp offset=%0d track=%0d chop=%0d on=%0b vel=%0d last=%0b",
							$time, want.offset, want.track, want.chop, want.on_flag, want.vel,
							want.last);
						$display("%0t: got offset=%0d track=%0d chop=%0d on=%0b vel=%0d last=%0b",
							$time, block_offset, out_track, out_chop, out_on, out_velocity,
							last_due);
					end
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_store_full();
		test_random();
		@(negedge clk);
		in_valid <= 1'b0;
		wait_for_fires();
		// room for the return to idle and any stray beat
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
